// ===== src/gdu_pkg.sv =====
package gdu_pkg;

  localparam int unsigned PcW = 3;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
    logic [4:0]  month_length;
    logic        is_leap;
    logic [4:0]  next_day;
    logic [3:0]  next_month;
    logic [13:0] next_year;
  } out_item_t;

  // Datapath operations
  typedef enum logic [1:0] {
    OP_NOP,
    OP_YINC,
    OP_YDEC,
    OP_MADD
  } op_e;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_Y_EQ,
    C_Y_GT,
    C_YI_MORE,
    C_YD_MORE,
    C_M_DONE,
    C_M_MORE
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
    logic           last;
  } uword_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic y_eq;
    logic y_gt;
    logic yi_more;
    logic yd_more;
    logic m_done;
    logic m_more;
  } dp_flags_t;

  // Program steps
  localparam logic [PcW-1:0] PcStart  = 3'd0;
  localparam logic [PcW-1:0] PcFwd    = 3'd2;
  localparam logic [PcW-1:0] PcBack   = 3'd4;
  localparam logic [PcW-1:0] PcMonth  = 3'd5;
  localparam logic [PcW-1:0] PcMLoop  = 3'd6;
  localparam logic [PcW-1:0] PcFinish = 3'd7;

  // Control store: jump to target when cond holds, else fall through.
  function automatic uword_t ucode(logic [PcW-1:0] pc);
    uword_t w;
    unique case (pc)
      3'd0: w = '{op: OP_NOP,  cond: C_Y_EQ,    target: PcMonth,  last: 1'b0};
      3'd1: w = '{op: OP_NOP,  cond: C_Y_GT,    target: PcBack,   last: 1'b0};
      3'd2: w = '{op: OP_YINC, cond: C_YI_MORE, target: PcFwd,    last: 1'b0};
      3'd3: w = '{op: OP_NOP,  cond: C_ALWAYS,  target: PcMonth,  last: 1'b0};
      3'd4: w = '{op: OP_YDEC, cond: C_YD_MORE, target: PcBack,   last: 1'b0};
      3'd5: w = '{op: OP_NOP,  cond: C_M_DONE,  target: PcFinish, last: 1'b0};
      3'd6: w = '{op: OP_MADD, cond: C_M_MORE,  target: PcMLoop,  last: 1'b0};
      3'd7: w = '{op: OP_NOP,  cond: C_NEVER,   target: PcStart,  last: 1'b1};
    endcase
    return w;
  endfunction

  // Leap year from the year modulo 400
  function automatic logic leap_of_mod400(logic [8:0] r);
    return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] add_mod7(logic [2:0] a, logic [2:0] b);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

  function automatic logic [2:0] mod7_5b(logic [4:0] x);
    logic [4:0] r;
    r = x;
    if (r >= 5'd28) begin
      r = r - 5'd28;
    end
    if (r >= 5'd14) begin
      r = r - 5'd14;
    end
    if (r >= 5'd7) begin
      r = r - 5'd7;
    end
    return r[2:0];
  endfunction

endpackage

// ===== src/gdu_sequencer.sv =====
module gdu_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               out_free_i,
  input  gdu_pkg::dp_flags_t flags_i,
  output gdu_pkg::op_e       op_o,
  output logic               busy_o,
  output logic               fire_o
);
  import gdu_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  logic           busy_q, busy_d;
  uword_t         word;
  logic           take;

  assign word = ucode(pc_q);

  always_comb begin
    unique case (word.cond)
      C_NEVER:   take = 1'b0;
      C_ALWAYS:  take = 1'b1;
      C_Y_EQ:    take = flags_i.y_eq;
      C_Y_GT:    take = flags_i.y_gt;
      C_YI_MORE: take = flags_i.yi_more;
      C_YD_MORE: take = flags_i.yd_more;
      C_M_DONE:  take = flags_i.m_done;
      C_M_MORE:  take = flags_i.m_more;
      default:   take = 1'b0;
    endcase
  end

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    fire_o = 1'b0;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        pc_d   = PcStart;
      end
    end else if (word.last) begin
      // hold on the last step until the result register is free
      if (out_free_i) begin
        fire_o = 1'b1;
        busy_d = 1'b0;
        pc_d   = PcStart;
      end
    end else if (take) begin
      pc_d = word.target;
    end else begin
      pc_d = pc_q + PcW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= PcStart;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

  assign op_o   = busy_q ? word.op : OP_NOP;
  assign busy_o = busy_q;

  a_idle_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> pc_q == PcStart)
    else $error("step counter not parked while idle");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i)
    else $error("start while busy");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && word.last && !out_free_i |=> busy_q && pc_q == PcFinish)
    else $error("finish step left while result register full");

endmodule

// ===== src/gdu_datapath.sv =====
module gdu_datapath #(
  parameter int unsigned BASE_YEAR = 1900
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  gdu_pkg::in_item_t  in_i,
  input  gdu_pkg::op_e       op_i,
  output gdu_pkg::dp_flags_t flags_o,
  output gdu_pkg::out_item_t result_o
);
  import gdu_pkg::*;

  localparam logic [13:0] BaseYear = 14'(BASE_YEAR);
  localparam logic [8:0]  BaseMod  = 9'(BASE_YEAR % 400);

  logic [13:0] year_q, year_d;
  logic [4:0]  day_q, day_d;
  logic [3:0]  mon_q, mon_d;
  logic [13:0] year_cursor_q, year_cursor_d;
  logic [8:0]  ymod_q, ymod_d;        // year_cursor mod 400
  logic [2:0]  weekday_accum_q, weekday_accum_d;
  logic [3:0]  month_cursor_q, month_cursor_d;
  logic [8:0]  ordinal_accum_q, ordinal_accum_d;

  logic [8:0]  ymod_inc, ymod_dec;
  logic        leap_cur, leap_prev;
  logic [4:0]  cur_len;
  logic [4:0]  mlen, dc;
  logic [13:0] yc_inc, yc_dec;

  assign ymod_inc  = (ymod_q == 9'd399) ? 9'd0 : ymod_q + 9'd1;
  assign ymod_dec  = (ymod_q == 9'd0) ? 9'd399 : ymod_q - 9'd1;
  assign leap_cur  = leap_of_mod400(ymod_q);
  assign leap_prev = leap_of_mod400(ymod_dec);
  assign cur_len   = month_len(month_cursor_q, leap_cur);
  assign yc_inc    = year_cursor_q + 14'd1;
  assign yc_dec    = year_cursor_q - 14'd1;

  always_comb begin
    year_d          = year_q;
    day_d           = day_q;
    mon_d           = mon_q;
    year_cursor_d   = year_cursor_q;
    ymod_d          = ymod_q;
    weekday_accum_d = weekday_accum_q;
    month_cursor_d  = month_cursor_q;
    ordinal_accum_d = ordinal_accum_q;
    if (load_i) begin
      year_d = in_i.year;
      day_d  = in_i.day;
      if (in_i.month == 4'd0) begin
        mon_d = 4'd1;
      end else if (in_i.month > 4'd12) begin
        mon_d = 4'd12;
      end else begin
        mon_d = in_i.month;
      end
      year_cursor_d   = BaseYear;
      ymod_d          = BaseMod;
      weekday_accum_d = 3'd0;
      month_cursor_d  = 4'd1;
      ordinal_accum_d = 9'd0;
    end else begin
      unique case (op_i)
        OP_YINC: begin
          // 365 + leap days shift the weekday by 1 + leap
          weekday_accum_d = add_mod7(weekday_accum_q, {2'b00, leap_cur} + 3'd1);
          year_cursor_d   = yc_inc;
          ymod_d          = ymod_inc;
        end
        OP_YDEC: begin
          weekday_accum_d = add_mod7(weekday_accum_q, 3'd6 - {2'b00, leap_prev});
          year_cursor_d   = yc_dec;
          ymod_d          = ymod_dec;
        end
        OP_MADD: begin
          weekday_accum_d = add_mod7(weekday_accum_q, 3'(cur_len - 5'd28));
          ordinal_accum_d = ordinal_accum_q + {4'b0000, cur_len};
          month_cursor_d  = month_cursor_q + 4'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q          <= '0;
      day_q           <= '0;
      mon_q           <= 4'd1;
      year_cursor_q   <= '0;
      ymod_q          <= '0;
      weekday_accum_q <= '0;
      month_cursor_q  <= 4'd1;
      ordinal_accum_q <= '0;
    end else begin
      year_q          <= year_d;
      day_q           <= day_d;
      mon_q           <= mon_d;
      year_cursor_q   <= year_cursor_d;
      ymod_q          <= ymod_d;
      weekday_accum_q <= weekday_accum_d;
      month_cursor_q  <= month_cursor_d;
      ordinal_accum_q <= ordinal_accum_d;
    end
  end

  assign flags_o.y_eq    = (year_cursor_q == year_q);
  assign flags_o.y_gt    = (year_cursor_q > year_q);
  assign flags_o.yi_more = (yc_inc != year_q);
  assign flags_o.yd_more = (yc_dec != year_q);
  assign flags_o.m_done  = (month_cursor_q >= mon_q);
  assign flags_o.m_more  = ((month_cursor_q + 4'd1) < mon_q);

  // Final step: cursor equals year, so ymod_q holds year mod 400
  assign mlen = month_len(mon_q, leap_cur);

  always_comb begin
    if (day_q == 5'd0) begin
      dc = 5'd1;
    end else if (day_q > mlen) begin
      dc = mlen;
    end else begin
      dc = day_q;
    end
  end

  always_comb begin
    result_o.weekday      = add_mod7(weekday_accum_q, mod7_5b(dc - 5'd1));
    result_o.day_of_year  = ordinal_accum_q + {4'b0000, dc};
    result_o.month_length = mlen;
    result_o.is_leap      = leap_cur;
    result_o.next_day     = dc + 5'd1;
    result_o.next_month   = mon_q;
    result_o.next_year    = year_q;
    if (dc == mlen) begin
      result_o.next_day = 5'd1;
      if (mon_q == 4'd12) begin
        result_o.next_month = 4'd1;
        result_o.next_year  = year_q + 14'd1;
      end else begin
        result_o.next_month = mon_q + 4'd1;
      end
    end
  end

  a_wd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    weekday_accum_q != 3'd7)
    else $error("weekday accumulator out of range");

endmodule

// ===== src/gregorian_date_unit.sv =====
// Gregorian date unit: weekday, ordinal day, month length, leap flag and the
// following date for one calendar date per transaction.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): day, month, year.
// Month 0 reads as January, months above 12 as December; day 0 reads as 1 and
// days past the month end saturate to the last day. All outputs describe the
// corrected date.
// Output channel (out_valid_o / out_ready_o / out_data_o): one result per input.
//
// A small microcoded sequencer walks the year cursor from BASE_YEAR (a Monday
// on January 1) to the input year, one year per cycle, then the months, one
// month per cycle. The next transaction is accepted once the result has been
// written to the output register, so one transaction is in flight at a time.
// in_ready_o is high whenever the sequencer is idle, also while a finished
// result waits in the output register. If the receiver stalls, the next
// transaction runs up to its finish step and holds there until the output
// register frees.
// Reset clears the sequencer to idle and the output register to empty.
module gregorian_date_unit #(
  parameter int unsigned BASE_YEAR = 1900
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gdu_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gdu_pkg::out_item_t out_data_o
);
  import gdu_pkg::*;

  logic      start;
  logic      busy;
  logic      fire;
  logic      out_free;
  op_e       op;
  dp_flags_t flags;
  out_item_t result;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  assign in_ready_o = !busy;
  assign start      = in_valid_i && !busy;
  // output register can take a new result this cycle
  assign out_free   = !out_valid_q || out_ready_i;

  gdu_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .out_free_i (out_free),
    .flags_i    (flags),
    .op_o       (op),
    .busy_o     (busy),
    .fire_o     (fire)
  );

  gdu_datapath #(
    .BASE_YEAR (BASE_YEAR)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (start),
    .in_i     (in_data_i),
    .op_i     (op),
    .flags_o  (flags),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (fire) begin
      out_valid_d = 1'b1;
      out_d       = result;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/sv/gregorian_date_unit_tb.sv =====
module gregorian_date_unit_tb;
  import gdu_pkg::*;

  localparam int unsigned BaseYear = 1900;
  localparam int unsigned ClkPeriod = 20;
  localparam int unsigned ResetCycles = 12;
  // Slowest date is year 16383, with the longest year walk plus the month
  // walk. The watchdog assumes every transaction takes that long, plus
  // stalls on both sides, with a wide margin.
  localparam int unsigned MaxLatency = 16384 + 32;
  localparam int unsigned CycleLimit = 8_000_000;
  localparam int unsigned RandomPerPhase = 26;

  // Weekday codes used in the hand-written rows
  localparam int unsigned WdMonday = 0;
  localparam int unsigned WdTuesday = 1;
  localparam int unsigned WdFriday = 4;

  // One row of the directed table: the date, and where the answer is obvious
  // from the calendar, the answer typed in by hand.
  typedef struct packed {
    in_item_t  date;
    logic      known;
    out_item_t answer;
  } date_case_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  out_item_t   expected_results[$];
  date_case_t  date_cases[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  gregorian_date_unit #(
    .BASE_YEAR(BaseYear)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    case (m)
      2:              return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:    return 30;
      default:        return 31;
    endcase
  endfunction

  // Days in the years 0 .. y-1, modulo 7 (proleptic Gregorian)
  function automatic int unsigned year_offset_mod7(int unsigned y);
    int unsigned leaps;
    leaps = (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    return (365 * y + leaps) % 7;
  endfunction

  function automatic in_item_t make_date(int unsigned d, int unsigned m, int unsigned y);
    in_item_t it;
    it.day = 5'(d);
    it.month = 4'(m);
    it.year = 14'(y);
    return it;
  endfunction

  function automatic out_item_t make_result(int unsigned wd, int unsigned doy,
                                            int unsigned mlen, int unsigned lp,
                                            int unsigned nd, int unsigned nm,
                                            int unsigned ny);
    out_item_t r;
    r.weekday = 3'(wd);
    r.day_of_year = 9'(doy);
    r.month_length = 5'(mlen);
    r.is_leap = 1'(lp);
    r.next_day = 5'(nd);
    r.next_month = 4'(nm);
    r.next_year = 14'(ny);
    return r;
  endfunction

  // Full answer for one date: out-of-range month and day are clamped first,
  // and everything, the following date included, describes the clamped date.
  function automatic out_item_t calendar_facts(in_item_t it);
    int unsigned d, m, y, mlen, doy, wd, k, nd, nm, ny;
    d = it.day;
    m = it.month;
    y = it.year;
    if (m == 0) m = 1;
    if (m > 12) m = 12;
    mlen = days_in_month(m, y);
    if (d == 0) d = 1;
    if (d > mlen) d = mlen;
    doy = d;
    for (k = 1; k < m; k++) doy += days_in_month(k, y);
    wd = (year_offset_mod7(y) + 7 - year_offset_mod7(BaseYear) + (doy - 1) % 7) % 7;
    nd = d + 1;
    nm = m;
    ny = y;
    if (d == mlen) begin
      nd = 1;
      if (m == 12) begin
        nm = 1;
        ny = y + 1;  // 16383 wraps to 0 in the 14-bit field
      end else begin
        nm = m + 1;
      end
    end
    return make_result(wd, doy, mlen, leap_year(y), nd, nm, ny);
  endfunction

  // Mostly well-formed dates near the base year (short year walk), a slice
  // over the whole 14-bit year range, and some raw noise in day and month.
  // Month ends are favored so the day/month/year wraps get exercised.
  function automatic in_item_t random_date();
    int unsigned d, m, y;
    if ($urandom_range(99) < 12) begin
      y = $urandom_range(16383);
    end else begin
      y = $urandom_range(BaseYear + 200, BaseYear - 30);
    end
    if ($urandom_range(99) < 15) begin
      d = $urandom_range(31);
      m = $urandom_range(15);
    end else begin
      m = $urandom_range(12, 1);
      if ($urandom_range(3) == 0) begin
        d = days_in_month(m, y);
      end else begin
        d = $urandom_range(days_in_month(m, y), 1);
      end
    end
    return make_date(d, m, y);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one transaction per call. Valid stays up across back-to-back
  // transactions; it only drops while the sender idles.
  // ---------------------------------------------------------------------------

  task automatic drive_date(in_item_t it, out_item_t answer);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk_i);
    while (in_ready !== 1'b1) @(posedge clk_i);
    // accepted at this edge
    expected_results.push_back(answer);
  endtask

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready toggles at random, every accepted transaction is
  // checked against the oldest pending answer.
  // ---------------------------------------------------------------------------

  initial begin
    out_item_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid === 1'b1 && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("weekday", want.weekday, out_data.weekday);
          compare_field("day_of_year", want.day_of_year, out_data.day_of_year);
          compare_field("month_length", want.month_length, out_data.month_length);
          compare_field("is_leap", want.is_leap, out_data.is_leap);
          compare_field("next_day", want.next_day, out_data.next_day);
          compare_field("next_month", want.next_month, out_data.next_month);
          compare_field("next_year", want.next_year, out_data.next_year);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    // Directed table. Known answers: base-year New Year's Day (a Monday),
    // the same date reached through day zero and month zero, a leap day and
    // the last day of year 9999.
    date_cases.push_back('{make_date(1, 1, 1900), 1'b1,
                           make_result(WdMonday, 1, 31, 0, 2, 1, 1900)});
    date_cases.push_back('{make_date(0, 0, 1900), 1'b1,
                           make_result(WdMonday, 1, 31, 0, 2, 1, 1900)});
    date_cases.push_back('{make_date(29, 2, 2000), 1'b1,
                           make_result(WdTuesday, 60, 29, 1, 1, 3, 2000)});
    date_cases.push_back('{make_date(31, 12, 9999), 1'b1,
                           make_result(WdFriday, 365, 31, 0, 1, 1, 10000)});
    // Answers from the predictor
    date_cases.push_back('{make_date(28, 2, 1900), 1'b0, '0});   // century, not leap
    date_cases.push_back('{make_date(31, 2, 1900), 1'b0, '0});   // day past end -> 28
    date_cases.push_back('{make_date(31, 2, 2024), 1'b0, '0});   // day past end -> 29
    date_cases.push_back('{make_date(31, 4, 2023), 1'b0, '0});   // day past end -> 30
    date_cases.push_back('{make_date(15, 13, 2023), 1'b0, '0});  // month above 12
    date_cases.push_back('{make_date(31, 0, 1950), 1'b0, '0});   // month zero, Jan 31
    date_cases.push_back('{make_date(31, 15, 16383), 1'b0, '0}); // year wraps to 0
    date_cases.push_back('{make_date(0, 1, 0), 1'b0, '0});       // year zero
    date_cases.push_back('{make_date(29, 2, 0), 1'b0, '0});      // year zero is leap
    date_cases.push_back('{make_date(1, 1, 1583), 1'b0, '0});    // counts backwards
    date_cases.push_back('{make_date(31, 12, 1899), 1'b0, '0});  // into the base year
    date_cases.push_back('{make_date(30, 6, 1999), 1'b0, '0});
    date_cases.push_back('{make_date(31, 1, 2001), 1'b0, '0});
    date_cases.push_back('{make_date(30, 11, 2023), 1'b0, '0});
    date_cases.push_back('{make_date(31, 12, 2023), 1'b0, '0});
    date_cases.push_back('{make_date(29, 2, 2100), 1'b0, '0});   // century, not leap
    date_cases.push_back('{make_date(29, 2, 2400), 1'b0, '0});   // 400-year leap
    date_cases.push_back('{make_date(16, 8, 8191), 1'b0, '0});
    date_cases.push_back('{make_date(1, 12, 8192), 1'b0, '0});

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase 1: sender rarely idles, receiver often stalls
    send_idle_pct = 17;
    recv_idle_pct = 62;
    foreach (date_cases[i]) begin
      drive_date(date_cases[i].date,
                 date_cases[i].known ? date_cases[i].answer
                                     : calendar_facts(date_cases[i].date));
    end
    for (int n = 0; n < RandomPerPhase; n++) begin
      in_item_t it;
      it = random_date();
      drive_date(it, calendar_facts(it));
    end

    // Phase 2: the other way round
    send_idle_pct = 62;
    recv_idle_pct = 17;
    for (int n = 0; n < RandomPerPhase; n++) begin
      in_item_t it;
      it = random_date();
      drive_date(it, calendar_facts(it));
    end

    // Phase 3: full pressure on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < RandomPerPhase; n++) begin
      in_item_t it;
      it = random_date();
      drive_date(it, calendar_facts(it));
    end
    in_valid <= 1'b0;

    // Drain, then give a stray extra transaction time to show up
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (MaxLatency) @(posedge clk_i);

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
